// File: rtl/dpc_pkg.sv
// Shared widths, constants, codes and command types for the depth-to-point-cloud block.
package dpc_pkg;

  localparam int unsigned MAX_DIM_DEF = 2048;

  localparam int unsigned DEPTH_W   = 16;
  localparam int unsigned COLOUR_W  = 8;
  localparam int unsigned DIM_REG_W = 12;
  localparam int unsigned SCALE_W   = 24;
  localparam int unsigned INVF_W    = 24;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 24;

  localparam int unsigned OP_W      = 24;
  localparam int unsigned PROD_W    = 2 * OP_W;
  localparam int unsigned Z_W       = DEPTH_W + SCALE_W;
  localparam int unsigned T_W       = Z_W + INVF_W;
  localparam int unsigned COORD_W   = 32;
  localparam int unsigned RND_SHIFT = 25;

  localparam logic [DIM_REG_W-1:0] FRAME_WIDTH_RST  = 12'd640;
  localparam logic [DIM_REG_W-1:0] FRAME_HEIGHT_RST = 12'd480;
  localparam logic [SCALE_W-1:0]   DEPTH_SCALE_RST  = 24'd65536;
  localparam logic [INVF_W-1:0]    INV_FOCAL_RST    = 24'd29361;

  localparam logic [COORD_W-1:0] COORD_MAX = 32'h7FFF_FFFF;
  localparam logic [COORD_W-1:0] COORD_MIN = 32'h8000_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH,
    CFG_FRAME_HEIGHT,
    CFG_DEPTH_SCALE,
    CFG_INV_FOCAL
  } cfg_idx_e;

  typedef enum logic [2:0] {
    A_DEPTH,
    A_Z_LO,
    A_Z_HI,
    A_T_LO,
    A_T_MID,
    A_T_HI
  } a_sel_e;

  typedef enum logic [1:0] {
    B_SCALE,
    B_INV_FOCAL,
    B_MAG_X,
    B_MAG_Y
  } b_sel_e;

  typedef enum logic [1:0] {
    WB_NONE,
    WB_Z,
    WB_T,
    WB_ACC
  } wb_e;

  typedef struct packed {
    a_sel_e     a_sel;
    b_sel_e     b_sel;
    wb_e        wb;
    logic       clear;
    logic [1:0] slice;
    logic       store_x;
  } mul_cmd_t;

  typedef struct packed {
    logic     accept;
    mul_cmd_t mul;
    logic     out_load;
  } dp_cmd_t;

endpackage

// File: rtl/dpc_ctrl.sv
// Sequencer for the shared multiplier and the input and output handshakes.
module dpc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output dpc_pkg::dp_cmd_t  cmd_o
);
  import dpc_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_Z,
    S_Z_WAIT,
    S_T0,
    S_T1,
    S_T_WAIT,
    S_X0,
    S_X1,
    S_X2,
    S_Y0,
    S_Y1,
    S_Y2,
    S_Y_WAIT,
    S_OUT
  } state_e;

  state_e   state_q, state_d;
  logic     out_valid_q, out_valid_d;
  logic     out_free;
  dp_cmd_t  cmd;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    cmd         = '0;
    state_d     = state_q;
    cmd.mul.wb  = WB_NONE;
    case (state_q)
      S_IDLE: begin
        cmd.accept = in_valid_i;
        if (in_valid_i) begin
          state_d = S_Z;
        end
      end
      S_Z: begin
        cmd.mul.a_sel = A_DEPTH;
        cmd.mul.b_sel = B_SCALE;
        cmd.mul.wb    = WB_Z;
        state_d       = S_Z_WAIT;
      end
      S_Z_WAIT: begin
        state_d = S_T0;
      end
      S_T0: begin
        cmd.mul.a_sel = A_Z_LO;
        cmd.mul.b_sel = B_INV_FOCAL;
        cmd.mul.wb    = WB_T;
        cmd.mul.clear = 1'b1;
        cmd.mul.slice = 2'd0;
        state_d       = S_T1;
      end
      S_T1: begin
        cmd.mul.a_sel = A_Z_HI;
        cmd.mul.b_sel = B_INV_FOCAL;
        cmd.mul.wb    = WB_T;
        cmd.mul.slice = 2'd1;
        state_d       = S_T_WAIT;
      end
      S_T_WAIT: begin
        state_d = S_X0;
      end
      S_X0: begin
        cmd.mul.a_sel = A_T_LO;
        cmd.mul.b_sel = B_MAG_X;
        cmd.mul.wb    = WB_ACC;
        cmd.mul.clear = 1'b1;
        cmd.mul.slice = 2'd0;
        state_d       = S_X1;
      end
      S_X1: begin
        cmd.mul.a_sel = A_T_MID;
        cmd.mul.b_sel = B_MAG_X;
        cmd.mul.wb    = WB_ACC;
        cmd.mul.slice = 2'd1;
        state_d       = S_X2;
      end
      S_X2: begin
        cmd.mul.a_sel = A_T_HI;
        cmd.mul.b_sel = B_MAG_X;
        cmd.mul.wb    = WB_ACC;
        cmd.mul.slice = 2'd2;
        state_d       = S_Y0;
      end
      S_Y0: begin
        cmd.mul.a_sel   = A_T_LO;
        cmd.mul.b_sel   = B_MAG_Y;
        cmd.mul.wb      = WB_ACC;
        cmd.mul.clear   = 1'b1;
        cmd.mul.slice   = 2'd0;
        cmd.mul.store_x = 1'b1;
        state_d         = S_Y1;
      end
      S_Y1: begin
        cmd.mul.a_sel = A_T_MID;
        cmd.mul.b_sel = B_MAG_Y;
        cmd.mul.wb    = WB_ACC;
        cmd.mul.slice = 2'd1;
        state_d       = S_Y2;
      end
      S_Y2: begin
        cmd.mul.a_sel = A_T_HI;
        cmd.mul.b_sel = B_MAG_Y;
        cmd.mul.wb    = WB_ACC;
        cmd.mul.slice = 2'd2;
        state_d       = S_Y_WAIT;
      end
      S_Y_WAIT: begin
        state_d = S_OUT;
      end
      S_OUT: begin
        cmd.out_load = out_free;
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_valid_d = cmd.out_load || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign cmd_o       = cmd;

endmodule

// File: rtl/dpc_datapath.sv
// Config registers, pixel counters, shared 24x24 multiplier, accumulators and output register.
module dpc_datapath #(
  parameter int unsigned MAX_DIM = dpc_pkg::MAX_DIM_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [dpc_pkg::CFG_IDX_W-1:0]     cfg_addr_i,
  input  logic [dpc_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  input  logic [dpc_pkg::DEPTH_W-1:0]       depth_raw_i,
  input  logic [dpc_pkg::COLOUR_W-1:0]      red_in_i,
  input  logic [dpc_pkg::COLOUR_W-1:0]      green_in_i,
  input  logic [dpc_pkg::COLOUR_W-1:0]      blue_in_i,
  input  dpc_pkg::dp_cmd_t                  cmd_i,
  output logic signed [dpc_pkg::COORD_W-1:0] point_x_o,
  output logic signed [dpc_pkg::COORD_W-1:0] point_y_o,
  output logic signed [dpc_pkg::COORD_W-1:0] point_z_o,
  output logic [dpc_pkg::COLOUR_W-1:0]      red_out_o,
  output logic [dpc_pkg::COLOUR_W-1:0]      green_out_o,
  output logic [dpc_pkg::COLOUR_W-1:0]      blue_out_o,
  output logic                              frame_end_o
);
  import dpc_pkg::*;

  localparam int unsigned DW   = $clog2(MAX_DIM);
  localparam int unsigned DIMW = $clog2(MAX_DIM + 1);
  localparam int unsigned SW   = DIMW + 2;
  localparam int unsigned MW   = SW - 1;
  localparam int unsigned ACCW = T_W + MW + 1;
  localparam int unsigned QW   = ACCW - RND_SHIFT;

  function automatic logic [DIMW-1:0] eff_dim(input logic [DIM_REG_W-1:0] v);
    if (v == '0) begin
      return DIMW'(1);
    end else if (32'(v) > MAX_DIM) begin
      return DIMW'(MAX_DIM);
    end else begin
      return DIMW'(v);
    end
  endfunction

  // round half away from zero: accumulator was seeded with half an LSB
  function automatic logic [COORD_W-1:0] sat_coord(input logic [ACCW-1:0] acc,
                                                   input logic neg);
    logic [QW-1:0] q;
    q = acc[ACCW-1:RND_SHIFT];
    if (|q[QW-1:COORD_W-1]) begin
      return neg ? COORD_MIN : COORD_MAX;
    end else begin
      return neg ? (COORD_W'(0) - q[COORD_W-1:0]) : q[COORD_W-1:0];
    end
  endfunction

  logic [DIM_REG_W-1:0] frame_width_q, frame_height_q;
  logic [SCALE_W-1:0]   depth_scale_q;
  logic [INVF_W-1:0]    inv_focal_q;

  logic [DW-1:0]   col_q, col_d, row_q, row_d;
  logic [DIMW-1:0] w_eff, h_eff;
  logic [SW-1:0]   dx, dy, dx_neg, dy_neg;
  logic [MW-1:0]   mag_x, mag_y;
  logic            last_col, last_row;

  logic [DEPTH_W-1:0]  depth_q;
  logic [COLOUR_W-1:0] red_q, green_q, blue_q;
  logic [MW-1:0]       mag_x_q, mag_y_q;
  logic                neg_x_q, neg_y_q, fend_q;

  logic [OP_W-1:0]   op_a, op_b;
  logic [PROD_W-1:0] prod_q;
  mul_cmd_t          cmd_q;

  logic [Z_W-1:0]     z_q;
  logic [T_W-1:0]     t_q, t_base, t_add;
  logic [ACCW-1:0]    acc_q, acc_base, acc_add;
  logic [COORD_W-1:0] x_q;

  logic [COORD_W-1:0]  point_x_q, point_y_q, point_z_q;
  logic [COLOUR_W-1:0] red_out_q, green_out_q, blue_out_q;
  logic                frame_end_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= FRAME_WIDTH_RST;
      frame_height_q <= FRAME_HEIGHT_RST;
      depth_scale_q  <= DEPTH_SCALE_RST;
      inv_focal_q    <= INV_FOCAL_RST;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CFG_FRAME_WIDTH:  frame_width_q  <= cfg_wdata_i[DIM_REG_W-1:0];
        CFG_FRAME_HEIGHT: frame_height_q <= cfg_wdata_i[DIM_REG_W-1:0];
        CFG_DEPTH_SCALE:  depth_scale_q  <= cfg_wdata_i[SCALE_W-1:0];
        CFG_INV_FOCAL:    inv_focal_q    <= cfg_wdata_i[INVF_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    w_eff    = eff_dim(frame_width_q);
    h_eff    = eff_dim(frame_height_q);
    dx       = (SW'(col_q) << 1) - (SW'(w_eff) - SW'(1));
    dy       = (SW'(row_q) << 1) - (SW'(h_eff) - SW'(1));
    dx_neg   = SW'(0) - dx;
    dy_neg   = SW'(0) - dy;
    mag_x    = dx[SW-1] ? dx_neg[MW-1:0] : dx[MW-1:0];
    mag_y    = dy[SW-1] ? dy_neg[MW-1:0] : dy[MW-1:0];
    last_col = ((DIMW+1)'(col_q) + (DIMW+1)'(1)) >= (DIMW+1)'(w_eff);
    last_row = ((DIMW+1)'(row_q) + (DIMW+1)'(1)) >= (DIMW+1)'(h_eff);
    col_d    = col_q + DW'(1);
    row_d    = row_q;
    if (last_col) begin
      col_d = '0;
      row_d = last_row ? '0 : (row_q + DW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (cmd_i.accept) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      depth_q <= depth_raw_i;
      red_q   <= red_in_i;
      green_q <= green_in_i;
      blue_q  <= blue_in_i;
      mag_x_q <= mag_x;
      mag_y_q <= mag_y;
      neg_x_q <= dx[SW-1];
      neg_y_q <= dy[SW-1];
      fend_q  <= last_col && last_row;
    end
  end

  always_comb begin
    case (cmd_i.mul.a_sel)
      A_DEPTH: op_a = OP_W'(depth_q);
      A_Z_LO:  op_a = z_q[OP_W-1:0];
      A_Z_HI:  op_a = OP_W'(z_q[Z_W-1:OP_W]);
      A_T_LO:  op_a = t_q[OP_W-1:0];
      A_T_MID: op_a = t_q[2*OP_W-1:OP_W];
      A_T_HI:  op_a = OP_W'(t_q[T_W-1:2*OP_W]);
      default: op_a = '0;
    endcase
    case (cmd_i.mul.b_sel)
      B_SCALE:     op_b = OP_W'(depth_scale_q);
      B_INV_FOCAL: op_b = OP_W'(inv_focal_q);
      B_MAG_X:     op_b = OP_W'(mag_x_q);
      B_MAG_Y:     op_b = OP_W'(mag_y_q);
      default:     op_b = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= PROD_W'(op_a) * PROD_W'(op_b);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_q <= '0;
    end else begin
      cmd_q <= cmd_i.mul;
    end
  end

  always_comb begin
    t_base   = cmd_q.clear ? '0 : t_q;
    acc_base = cmd_q.clear ? (ACCW'(1) << (RND_SHIFT - 1)) : acc_q;
    case (cmd_q.slice)
      2'd0: begin
        t_add   = T_W'(prod_q);
        acc_add = ACCW'(prod_q);
      end
      2'd1: begin
        t_add   = T_W'(prod_q) << OP_W;
        acc_add = ACCW'(prod_q) << OP_W;
      end
      default: begin
        t_add   = T_W'(prod_q) << (2 * OP_W);
        acc_add = ACCW'(prod_q) << (2 * OP_W);
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    case (cmd_q.wb)
      WB_Z:    z_q   <= prod_q[Z_W-1:0];
      WB_T:    t_q   <= t_base + t_add;
      WB_ACC:  acc_q <= acc_base + acc_add;
      default: ;
    endcase
    if (cmd_q.store_x) begin
      x_q <= sat_coord(acc_q, neg_x_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      point_x_q   <= x_q;
      point_y_q   <= sat_coord(acc_q, neg_y_q);
      point_z_q   <= (|z_q[Z_W-1:COORD_W-1]) ? COORD_MAX : z_q[COORD_W-1:0];
      red_out_q   <= red_q;
      green_out_q <= green_q;
      blue_out_q  <= blue_q;
      frame_end_q <= fend_q;
    end
  end

  assign point_x_o   = $signed(point_x_q);
  assign point_y_o   = $signed(point_y_q);
  assign point_z_o   = $signed(point_z_q);
  assign red_out_o   = red_out_q;
  assign green_out_o = green_out_q;
  assign blue_out_o  = blue_out_q;
  assign frame_end_o = frame_end_q;

endmodule

// File: rtl/depth_pixel_to_point_cloud.sv
// Top level: back-projects raster-order depth pixels into coloured 3-D points.
//
// Input channel: in_valid_i / in_stall_o carry one pixel per beat (raw depth
// and RGB). Output channel: out_valid_o / out_stall_i carry one point per beat
// (x, y, z in signed Q15.16, the colour, and a flag on the last pixel of a
// frame). A beat moves on a clock edge with valid high and stall low.
// Each pixel runs through one shared 24x24 multiplier nine times in
// sequence (z, z/f in two slices, x and y in three slices each), and no new
// pixel is taken until the point of the last one is loaded into the output
// register. The output register lets the next pixel enter while the
// previous point waits; a stalled point holds until taken, and the block
// then waits with the finished point before loading it.
// Config writes (cfg_we_i, cfg_addr_i, cfg_wdata_i) go in between pixels.
// Reset restores 640x480, unity depth scale and the default 1/f, and starts
// the column and row counters at the top-left pixel.
module depth_pixel_to_point_cloud #(
  parameter int unsigned MAX_DIM = dpc_pkg::MAX_DIM_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [dpc_pkg::CFG_IDX_W-1:0]      cfg_addr_i,
  input  logic [dpc_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [dpc_pkg::DEPTH_W-1:0]        depth_raw_i,
  input  logic [dpc_pkg::COLOUR_W-1:0]       red_in_i,
  input  logic [dpc_pkg::COLOUR_W-1:0]       green_in_i,
  input  logic [dpc_pkg::COLOUR_W-1:0]       blue_in_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [dpc_pkg::COORD_W-1:0] point_x_o,
  output logic signed [dpc_pkg::COORD_W-1:0] point_y_o,
  output logic signed [dpc_pkg::COORD_W-1:0] point_z_o,
  output logic [dpc_pkg::COLOUR_W-1:0]       red_out_o,
  output logic [dpc_pkg::COLOUR_W-1:0]       green_out_o,
  output logic [dpc_pkg::COLOUR_W-1:0]       blue_out_o,
  output logic                               frame_end_o
);
  import dpc_pkg::*;

  dp_cmd_t dp_cmd;

  dpc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (dp_cmd)
  );

  dpc_datapath #(
    .MAX_DIM (MAX_DIM)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .depth_raw_i (depth_raw_i),
    .red_in_i    (red_in_i),
    .green_in_i  (green_in_i),
    .blue_in_i   (blue_in_i),
    .cmd_i       (dp_cmd),
    .point_x_o   (point_x_o),
    .point_y_o   (point_y_o),
    .point_z_o   (point_z_o),
    .red_out_o   (red_out_o),
    .green_out_o (green_out_o),
    .blue_out_o  (blue_out_o),
    .frame_end_o (frame_end_o)
  );

  // a taken pixel keeps the block busy on the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input taken again straight after a beat");

  // the output register is only overwritten when free
  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dp_cmd.out_load |-> (!out_valid_o || !out_stall_i))
    else $error("point overwritten while stalled");

  // depth and scale are unsigned, so z never comes out negative
  a_z_non_negative: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !point_z_o[COORD_W-1])
    else $error("negative z on output");

  // loading a point and taking a pixel never coincide
  a_accept_load_apart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(dp_cmd.accept && dp_cmd.out_load))
    else $error("accept and output load in one cycle");

endmodule

// File: tb/tb_depth_pixel_to_point_cloud.sv
// Self-checking testbench for the depth pixel to point cloud back-projection block.
module tb_depth_pixel_to_point_cloud;
  timeunit 1ns;
  timeprecision 1ps;
  import dpc_pkg::*;

  localparam int unsigned IDLE_LIMIT   = 4000;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned RANDOM_PIXELS = 400;
  localparam int unsigned QUIET_PIXELS  = 120;
  localparam int unsigned LONG_PIXELS   = 40;

  typedef struct packed {
    logic [DEPTH_W-1:0]  depth;
    logic [COLOUR_W-1:0] red;
    logic [COLOUR_W-1:0] green;
    logic [COLOUR_W-1:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [COORD_W-1:0]  x;
    logic [COORD_W-1:0]  y;
    logic [COORD_W-1:0]  z;
    logic [COLOUR_W-1:0] red;
    logic [COLOUR_W-1:0] green;
    logic [COLOUR_W-1:0] blue;
    logic                last;
  } point_t;

  logic                        clk_i;
  logic                        rst_ni;
  logic                        cfg_we_i;
  logic [CFG_IDX_W-1:0]        cfg_addr_i;
  logic [CFG_DATA_W-1:0]       cfg_wdata_i;
  logic                        in_valid_i;
  logic                        in_stall_o;
  logic [DEPTH_W-1:0]          depth_raw_i;
  logic [COLOUR_W-1:0]         red_in_i;
  logic [COLOUR_W-1:0]         green_in_i;
  logic [COLOUR_W-1:0]         blue_in_i;
  logic                        out_valid_o;
  logic                        out_stall_i;
  logic signed [COORD_W-1:0]   point_x_o;
  logic signed [COORD_W-1:0]   point_y_o;
  logic signed [COORD_W-1:0]   point_z_o;
  logic [COLOUR_W-1:0]         red_out_o;
  logic [COLOUR_W-1:0]         green_out_o;
  logic [COLOUR_W-1:0]         blue_out_o;
  logic                        frame_end_o;

  depth_pixel_to_point_cloud u_top (.*);

  // predictor copy of the registers and raster counters
  logic [DIM_REG_W-1:0] cur_width     = FRAME_WIDTH_RST;
  logic [DIM_REG_W-1:0] cur_height    = FRAME_HEIGHT_RST;
  logic [SCALE_W-1:0]   cur_scale     = DEPTH_SCALE_RST;
  logic [INVF_W-1:0]    cur_inv_focal = INV_FOCAL_RST;
  logic [10:0]          col_pos       = '0;
  logic [10:0]          row_pos       = '0;

  point_t      pending_points[$];
  int unsigned n_errors  = 0;
  int unsigned n_pixels  = 0;
  int unsigned n_points  = 0;
  int unsigned n_frames  = 0;
  int unsigned n_configs = 0;
  int unsigned idle_cycles = 0;
  bit          quiet = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int unsigned clamp_dim(input logic [DIM_REG_W-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_DIM_DEF) return MAX_DIM_DEF;
    return 32'(v);
  endfunction

  function automatic logic [COORD_W-1:0] project_offset(input logic [63:0] t, input int d);
    logic [12:0] mag;
    logic [79:0] q;
    mag = 13'((d < 0) ? -d : d);
    q = ({16'd0, t} * 80'(mag) + (80'd1 << 24)) >> RND_SHIFT;
    if (d < 0) return (q >= 80'h8000_0000) ? COORD_MIN : -q[COORD_W-1:0];
    return (q > 80'h7FFF_FFFF) ? COORD_MAX : q[COORD_W-1:0];
  endfunction

  function automatic point_t back_project(input pixel_t px);
    int unsigned w, h;
    int          dx, dy;
    logic [39:0] z;
    logic [63:0] t;
    bit          last_col, last_row;
    point_t      pt;
    w = clamp_dim(cur_width);
    h = clamp_dim(cur_height);
    z = 40'(px.depth) * 40'(cur_scale);
    t = 64'(z) * 64'(cur_inv_focal);
    dx = 2 * int'(col_pos) - (int'(w) - 1);
    dy = 2 * int'(row_pos) - (int'(h) - 1);
    last_col = (col_pos + 1 >= w);
    last_row = (row_pos + 1 >= h);
    pt.x = project_offset(t, dx);
    pt.y = project_offset(t, dy);
    pt.z = (z > 40'h7FFF_FFFF) ? COORD_MAX : z[COORD_W-1:0];
    pt.red = px.red;
    pt.green = px.green;
    pt.blue = px.blue;
    pt.last = last_col && last_row;
    if (last_col) begin
      col_pos = '0;
      row_pos = last_row ? '0 : row_pos + 1'b1;
    end else begin
      col_pos = col_pos + 1'b1;
    end
    return pt;
  endfunction

  function automatic pixel_t random_pixel();
    pixel_t px;
    case ($urandom_range(9))
      0: px.depth = '0;
      1: px.depth = '1;
      default: px.depth = DEPTH_W'($urandom_range(65535));
    endcase
    px.red = COLOUR_W'($urandom);
    px.green = COLOUR_W'($urandom);
    px.blue = COLOUR_W'($urandom);
    return px;
  endfunction

  // mostly tiny frames; unused upper bits of the write word carry junk at times
  function automatic logic [CFG_DATA_W-1:0] random_dim_word();
    logic [DIM_REG_W-1:0] dim;
    logic [DIM_REG_W-1:0] junk;
    case ($urandom_range(9))
      0: dim = '0;
      1: dim = DIM_REG_W'($urandom_range(4095));
      2: dim = '1;
      default: dim = DIM_REG_W'($urandom_range(1, 6));
    endcase
    junk = $urandom_range(1) ? DIM_REG_W'($urandom) : '0;
    return {junk, dim};
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    n_errors++;
    $display("%0t: point %0d %s: expected %h, got %h", $time, n_points, what, want, got);
  endtask

  task automatic send_pixel(input pixel_t px);
    if (!quiet) begin
      while ($urandom_range(99) < 8) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid_i  <= 1'b1;
    depth_raw_i <= px.depth;
    red_in_i    <= px.red;
    green_in_i  <= px.green;
    blue_in_i   <= px.blue;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_points.push_back(back_project(px));
    n_pixels++;
  endtask

  task automatic wait_for_points();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_points.size() != 0);
  endtask

  task automatic write_config(input logic [CFG_DATA_W-1:0] width_word, height_word,
                              scale_word, focal_word);
    wait_for_points();
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= CFG_FRAME_WIDTH;
    cfg_wdata_i <= width_word;
    @(posedge clk_i);
    cur_width = width_word[DIM_REG_W-1:0];
    cfg_addr_i  <= CFG_FRAME_HEIGHT;
    cfg_wdata_i <= height_word;
    @(posedge clk_i);
    cur_height = height_word[DIM_REG_W-1:0];
    cfg_addr_i  <= CFG_DEPTH_SCALE;
    cfg_wdata_i <= scale_word;
    @(posedge clk_i);
    cur_scale = scale_word[SCALE_W-1:0];
    cfg_addr_i  <= CFG_INV_FOCAL;
    cfg_wdata_i <= focal_word;
    @(posedge clk_i);
    cur_inv_focal = focal_word[INVF_W-1:0];
    cfg_we_i <= 1'b0;
    n_configs++;
  endtask

  task automatic test_reset_defaults();
    send_pixel('{depth: '0, red: '0, green: '0, blue: '0});
    send_pixel('{depth: '1, red: '1, green: '1, blue: '1});
    send_pixel(random_pixel());
  endtask

  task automatic test_size_clamping();
    write_config(24'd0, 24'd0, 24'd65536, 24'd29361);
    send_pixel(random_pixel());
    send_pixel(random_pixel());
    write_config(24'hFFFFFF, 24'hFFFFFF, 24'd65536, 24'd29361);
    send_pixel(random_pixel());
    send_pixel(random_pixel());
  endtask

  task automatic test_saturation();
    write_config(24'd2, 24'd2, 24'hFFFFFF, 24'hFFFFFF);
    send_pixel('{depth: '1, red: 8'h5A, green: 8'hA5, blue: 8'h0F});
    send_pixel('{depth: '1, red: 8'hF0, green: 8'h00, blue: 8'hFF});
    send_pixel('{depth: '1, red: 8'h01, green: 8'h80, blue: 8'h7F});
    write_config(24'd2, 24'd2, 24'd0, 24'hFFFFFF);
    send_pixel('{depth: '1, red: 8'h12, green: 8'h34, blue: 8'h56});
  endtask

  task automatic test_shrink_mid_frame();
    write_config(24'd1, 24'd1, 24'd65536, 24'd29361);
    send_pixel(random_pixel());
    write_config(24'd8, 24'd8, 24'd65536, 24'd29361);
    repeat (4) send_pixel(random_pixel());
    // column now past the new last column
    write_config(24'd3, 24'd8, 24'd65536, 24'd29361);
    repeat (2) send_pixel(random_pixel());
    write_config(24'd1, 24'd8, 24'd65536, 24'd29361);
    repeat (4) send_pixel(random_pixel());
    // row now past the new last row
    write_config(24'd1, 24'd2, 24'd65536, 24'd29361);
    repeat (2) send_pixel(random_pixel());
  endtask

  task automatic test_long_frames();
    write_config(24'd2048, 24'd2, 24'h004000, 24'd29361);
    repeat (LONG_PIXELS) send_pixel(random_pixel());
    write_config(24'd1, 24'd2048, CFG_DATA_W'($urandom_range(24'hFFFFFF)),
                 CFG_DATA_W'($urandom_range(24'hFFFFFF)));
    repeat (LONG_PIXELS) send_pixel(random_pixel());
  endtask

  task automatic test_random_frames();
    int unsigned sent;
    int unsigned burst;
    logic [CFG_DATA_W-1:0] scale_word, focal_word;
    sent = 0;
    quiet = 1'b1;
    while (sent < RANDOM_PIXELS) begin
      if (sent >= QUIET_PIXELS) quiet = 1'b0;
      case ($urandom_range(4))
        0: scale_word = '0;
        1: scale_word = '1;
        2: scale_word = 24'd65536;
        default: scale_word = CFG_DATA_W'($urandom_range(24'hFFFFFF));
      endcase
      case ($urandom_range(4))
        0: focal_word = '0;
        1: focal_word = '1;
        2: focal_word = 24'd29361;
        default: focal_word = CFG_DATA_W'($urandom_range(24'hFFFFFF));
      endcase
      write_config(random_dim_word(), random_dim_word(), scale_word, focal_word);
      burst = $urandom_range(10, 40);
      for (int i = 0; i < burst; i++) begin
        send_pixel(random_pixel());
        if (i == burst / 2 && $urandom_range(7) == 0) wait_for_points();
      end
      sent += burst;
    end
    quiet = 1'b0;
  endtask

  always @(posedge clk_i) begin
    out_stall_i <= !quiet && ($urandom_range(99) < 8);
  end

  always @(posedge clk_i) begin
    point_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_points.size() == 0) begin
        report_mismatch("arrived with no pixel pending, x", '0, point_x_o);
      end else begin
        want = pending_points.pop_front();
        if (point_x_o !== want.x) report_mismatch("x", want.x, point_x_o);
        if (point_y_o !== want.y) report_mismatch("y", want.y, point_y_o);
        if (point_z_o !== want.z) report_mismatch("z", want.z, point_z_o);
        if (red_out_o !== want.red)
          report_mismatch("red", 32'(want.red), 32'(red_out_o));
        if (green_out_o !== want.green)
          report_mismatch("green", 32'(want.green), 32'(green_out_o));
        if (blue_out_o !== want.blue)
          report_mismatch("blue", 32'(want.blue), 32'(blue_out_o));
        if (frame_end_o !== want.last)
          report_mismatch("frame end", 32'(want.last), 32'(frame_end_o));
      end
      if (frame_end_o === 1'b1) n_frames++;
      n_points++;
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: timeout, no beat for %0d cycles", $time, idle_cycles);
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    rst_ni      <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_addr_i  <= CFG_FRAME_WIDTH;
    cfg_wdata_i <= '0;
    in_valid_i  <= 1'b0;
    depth_raw_i <= '0;
    red_in_i    <= '0;
    green_in_i  <= '0;
    blue_in_i   <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_size_clamping();
    test_saturation();
    test_shrink_mid_frame();
    test_random_frames();
    test_long_frames();

    wait_for_points();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Run covered %0d pixels, %0d points and %0d frame ends over %0d register settings,",
             n_pixels, n_points, n_frames, n_configs);
    $display("with clamped and shrunk frame sizes, saturated coordinates and very wide rows.");
    if (n_errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
